// ----- design/quaternion_pose_point_transform_defines.svh -----
// ----------------------------------------------------------------------------
// quaternion pose point transform - assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef QUATERNION_POSE_POINT_TRANSFORM_DEFINES_SVH
`define QUATERNION_POSE_POINT_TRANSFORM_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define QPT_ASSERT_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("qpt assertion failed: same-cycle implication");

// antecedent implies consequent after the delay given by argument n
`define QPT_ASSERT_DELAY(lbl, ant, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> ##n (cons)) \
    else $error("qpt assertion failed: delayed implication");

`endif

// ----- design/qpt_pkg.sv -----
// ----------------------------------------------------------------------------
// qpt_pkg
// shared defaults, register codes and width helpers of the pose transform
// ----------------------------------------------------------------------------
`default_nettype none

package qpt_pkg;

  // default widths of coordinates and quaternion components
  localparam int COORD_WIDTH_DEF = 32;
  localparam int QUAT_WIDTH_DEF  = 16;

  // configuration register index width
  localparam int CFG_INDEX_W = 3;

  // number of rotation matrix entries, row major
  localparam int MAT_ENTRIES = 9;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_QUAT_W,
    REG_QUAT_X,
    REG_QUAT_Y,
    REG_QUAT_Z,
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_OFFSET_Z
  } qpt_reg_t;

  // fraction bits of a quaternion component (two integer bits)
  function automatic int quat_frac(input int qw);
    return qw - 2;
  endfunction

  // width of a rounded matrix entry
  function automatic int mat_width(input int qw);
    return qw + 5;
  endfunction

  // fraction bits of a coordinate (half the word)
  function automatic int coord_frac(input int cw);
    return cw / 2;
  endfunction

endpackage

`default_nettype wire

// ----- design/quaternion_pose_point_transform.sv -----
// ----------------------------------------------------------------------------
// quaternion_pose_point_transform
// rigid pose (quaternion rotation plus translation) applied to a point stream
// ----------------------------------------------------------------------------
//  channel   ports                           handshake
//  input     in_point_x/y/z/w                start high and busy low
//  result    out_moved_x/y/z/w               out_valid strobe, one cycle
//  config    cfg_index, cfg_wdata            cfg_wr_en, no wait
//
//  one point enters every cycle; each result appears once its beat has
//  passed the five register stages (quaternion products, matrix entries,
//  multiply, row sum, saturate).
//  busy never rises: the pipeline does not stall and the receiver cannot stall.
//  reset is synchronous and active low; it restores the identity pose and
//  clears the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quaternion_pose_point_transform_defines.svh"

module quaternion_pose_point_transform #(
  parameter int COORD_WIDTH = qpt_pkg::COORD_WIDTH_DEF,
  parameter int QUAT_WIDTH  = qpt_pkg::QUAT_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [COORD_WIDTH-1:0]        in_point_x,
  input  wire logic signed [COORD_WIDTH-1:0]        in_point_y,
  input  wire logic signed [COORD_WIDTH-1:0]        in_point_z,
  input  wire logic signed [COORD_WIDTH-1:0]        in_point_w,
  output logic                                      out_valid,
  output logic signed [COORD_WIDTH-1:0]             out_moved_x,
  output logic signed [COORD_WIDTH-1:0]             out_moved_y,
  output logic signed [COORD_WIDTH-1:0]             out_moved_z,
  output logic signed [COORD_WIDTH-1:0]             out_moved_w,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [qpt_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [((COORD_WIDTH > QUAT_WIDTH) ? COORD_WIDTH : QUAT_WIDTH)-1:0] cfg_wdata
);
  import qpt_pkg::*;

  localparam int QW      = QUAT_WIDTH;
  localparam int CW      = COORD_WIDTH;
  localparam int QF      = quat_frac(QUAT_WIDTH);
  localparam int MW      = mat_width(QUAT_WIDTH);
  localparam int LATENCY = 5;
  localparam logic [QW-1:0] QUAT_ONE = QW'(1) << QF;

  logic signed [QW-1:0] quat_w_r, quat_x_r, quat_y_r, quat_z_r;
  logic signed [CW-1:0] offset_x_r, offset_y_r, offset_z_r;

  logic                 s1_valid_r, s2_valid_r;
  logic signed [CW-1:0] s1_x_r, s1_y_r, s1_z_r, s1_w_r;
  logic signed [CW-1:0] s2_x_r, s2_y_r, s2_z_r, s2_w_r;

  logic signed [MW-1:0] mat [MAT_ENTRIES];

  // pipeline takes a beat every cycle
  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_w_r   <= QUAT_ONE;
      quat_x_r   <= '0;
      quat_y_r   <= '0;
      quat_z_r   <= '0;
      offset_x_r <= '0;
      offset_y_r <= '0;
      offset_z_r <= '0;
    end else if (cfg_wr_en) begin
      case (qpt_reg_t'(cfg_index))
        REG_QUAT_W:   quat_w_r   <= cfg_wdata[QW-1:0];
        REG_QUAT_X:   quat_x_r   <= cfg_wdata[QW-1:0];
        REG_QUAT_Y:   quat_y_r   <= cfg_wdata[QW-1:0];
        REG_QUAT_Z:   quat_z_r   <= cfg_wdata[QW-1:0];
        REG_OFFSET_X: offset_x_r <= cfg_wdata[CW-1:0];
        REG_OFFSET_Y: offset_y_r <= cfg_wdata[CW-1:0];
        REG_OFFSET_Z: offset_z_r <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // point beats wait two stages while the matrix is built
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start & ~busy;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r <= in_point_x;
    s1_y_r <= in_point_y;
    s1_z_r <= in_point_z;
    s1_w_r <= in_point_w;
    s2_x_r <= s1_x_r;
    s2_y_r <= s1_y_r;
    s2_z_r <= s1_z_r;
    s2_w_r <= s1_w_r;
  end

  // matrix expansion, aligned with the point stages
  qpt_matrix #(
    .QUAT_WIDTH (QUAT_WIDTH)
  ) u_matrix (
    .clk    (clk),
    .quat_w (quat_w_r),
    .quat_x (quat_x_r),
    .quat_y (quat_y_r),
    .quat_z (quat_z_r),
    .mat_r  (mat)
  );

  // rotate, translate and saturate
  qpt_rotate #(
    .COORD_WIDTH (COORD_WIDTH),
    .QUAT_WIDTH  (QUAT_WIDTH)
  ) u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid_r),
    .point_x   (s2_x_r),
    .point_y   (s2_y_r),
    .point_z   (s2_z_r),
    .point_w   (s2_w_r),
    .mat       (mat),
    .offset_x  (offset_x_r),
    .offset_y  (offset_y_r),
    .offset_z  (offset_z_r),
    .out_valid (out_valid),
    .moved_x   (out_moved_x),
    .moved_y   (out_moved_y),
    .moved_z   (out_moved_z),
    .moved_w   (out_moved_w)
  );

  // every taken beat leaves the pipeline with out_valid
  `QPT_ASSERT_DELAY(a_beat_latency, start && !busy, 5, out_valid)
  // no result without a beat taken at the matching cycle
  `QPT_ASSERT_IMPL(a_no_spurious, out_valid, $past(start, LATENCY))
  // weight leaves with its own beat unchanged
  `QPT_ASSERT_IMPL(a_weight_pass, out_valid, out_moved_w == $past(in_point_w, LATENCY))

endmodule

`default_nettype wire

// ----- design/qpt_matrix.sv -----
// ----------------------------------------------------------------------------
// qpt_matrix
// two-stage expansion of the orientation quaternion into the 3x3 matrix
// ----------------------------------------------------------------------------
`default_nettype none

module qpt_matrix #(
  parameter int QUAT_WIDTH = qpt_pkg::QUAT_WIDTH_DEF
) (
  input  wire logic                                          clk,
  input  wire logic signed [QUAT_WIDTH-1:0]                  quat_w,
  input  wire logic signed [QUAT_WIDTH-1:0]                  quat_x,
  input  wire logic signed [QUAT_WIDTH-1:0]                  quat_y,
  input  wire logic signed [QUAT_WIDTH-1:0]                  quat_z,
  output logic signed [qpt_pkg::mat_width(QUAT_WIDTH)-1:0]   mat_r [qpt_pkg::MAT_ENTRIES]
);
  import qpt_pkg::*;

  localparam int QF = quat_frac(QUAT_WIDTH);
  localparam int PW = 2 * QUAT_WIDTH;
  localparam int EW = PW + 3;
  localparam int MW = mat_width(QUAT_WIDTH);

  // product slots
  localparam int P_XX = 0;
  localparam int P_YY = 1;
  localparam int P_ZZ = 2;
  localparam int P_XY = 3;
  localparam int P_XZ = 4;
  localparam int P_YZ = 5;
  localparam int P_WX = 6;
  localparam int P_WY = 7;
  localparam int P_WZ = 8;
  localparam int NPROD = 9;

  logic signed [PW-1:0] prod_nxt [NPROD];
  logic signed [PW-1:0] prod_r   [NPROD];
  logic signed [MW-1:0] mat_nxt  [MAT_ENTRIES];

  // 1 - 2(a+b), rounded half up to QF fraction bits
  function automatic logic signed [MW-1:0] diag_entry(input logic signed [PW-1:0] a,
                                                      input logic signed [PW-1:0] b);
    logic signed [EW-1:0] e;
    e = (EW'(1) <<< (2 * QF)) - ((EW'(a) + EW'(b)) <<< 1) + (EW'(1) <<< (QF - 1));
    return MW'(e >>> QF);
  endfunction

  // 2(a +/- b), rounded half up to QF fraction bits
  function automatic logic signed [MW-1:0] off_entry(input logic signed [PW-1:0] a,
                                                     input logic signed [PW-1:0] b,
                                                     input logic minus);
    logic signed [EW-1:0] s;
    logic signed [EW-1:0] e;
    s = minus ? (EW'(a) - EW'(b)) : (EW'(a) + EW'(b));
    e = (s <<< 1) + (EW'(1) <<< (QF - 1));
    return MW'(e >>> QF);
  endfunction

  // stage a: component products
  always_comb begin
    prod_nxt[P_XX] = PW'(quat_x) * PW'(quat_x);
    prod_nxt[P_YY] = PW'(quat_y) * PW'(quat_y);
    prod_nxt[P_ZZ] = PW'(quat_z) * PW'(quat_z);
    prod_nxt[P_XY] = PW'(quat_x) * PW'(quat_y);
    prod_nxt[P_XZ] = PW'(quat_x) * PW'(quat_z);
    prod_nxt[P_YZ] = PW'(quat_y) * PW'(quat_z);
    prod_nxt[P_WX] = PW'(quat_w) * PW'(quat_x);
    prod_nxt[P_WY] = PW'(quat_w) * PW'(quat_y);
    prod_nxt[P_WZ] = PW'(quat_w) * PW'(quat_z);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // stage b: matrix entries, row major
  always_comb begin
    mat_nxt[0] = diag_entry(prod_r[P_YY], prod_r[P_ZZ]);
    mat_nxt[1] = off_entry(prod_r[P_XY], prod_r[P_WZ], 1'b1);
    mat_nxt[2] = off_entry(prod_r[P_XZ], prod_r[P_WY], 1'b0);
    mat_nxt[3] = off_entry(prod_r[P_XY], prod_r[P_WZ], 1'b0);
    mat_nxt[4] = diag_entry(prod_r[P_XX], prod_r[P_ZZ]);
    mat_nxt[5] = off_entry(prod_r[P_YZ], prod_r[P_WX], 1'b1);
    mat_nxt[6] = off_entry(prod_r[P_XZ], prod_r[P_WY], 1'b1);
    mat_nxt[7] = off_entry(prod_r[P_YZ], prod_r[P_WX], 1'b0);
    mat_nxt[8] = diag_entry(prod_r[P_XX], prod_r[P_YY]);
  end

  always_ff @(posedge clk) begin
    mat_r <= mat_nxt;
  end

endmodule

`default_nettype wire

// ----- design/qpt_rotate.sv -----
// ----------------------------------------------------------------------------
// qpt_rotate
// three-stage rotate, translate, round and saturate of one point per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module qpt_rotate #(
  parameter int COORD_WIDTH = qpt_pkg::COORD_WIDTH_DEF,
  parameter int QUAT_WIDTH  = qpt_pkg::QUAT_WIDTH_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         in_valid,
  input  wire logic signed [COORD_WIDTH-1:0]                point_x,
  input  wire logic signed [COORD_WIDTH-1:0]                point_y,
  input  wire logic signed [COORD_WIDTH-1:0]                point_z,
  input  wire logic signed [COORD_WIDTH-1:0]                point_w,
  input  wire logic signed [qpt_pkg::mat_width(QUAT_WIDTH)-1:0] mat [qpt_pkg::MAT_ENTRIES],
  input  wire logic signed [COORD_WIDTH-1:0]                offset_x,
  input  wire logic signed [COORD_WIDTH-1:0]                offset_y,
  input  wire logic signed [COORD_WIDTH-1:0]                offset_z,
  output logic                                              out_valid,
  output logic signed [COORD_WIDTH-1:0]                     moved_x,
  output logic signed [COORD_WIDTH-1:0]                     moved_y,
  output logic signed [COORD_WIDTH-1:0]                     moved_z,
  output logic signed [COORD_WIDTH-1:0]                     moved_w
);
  import qpt_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int QF    = quat_frac(QUAT_WIDTH);
  localparam int CF    = coord_frac(COORD_WIDTH);
  localparam int MW    = mat_width(QUAT_WIDTH);
  localparam int PRW   = MW + CW;
  localparam int ROT_W = PRW + 3;
  localparam int RR_W  = ROT_W - QF;
  localparam int TW_W  = 2 * CW + 1;
  localparam int TR_W  = TW_W - CF;
  localparam int SUM_W = ((RR_W > TR_W) ? RR_W : TR_W) + 1;
  localparam int ROWS  = 3;

  logic signed [CW-1:0]    pt     [ROWS];
  logic signed [CW-1:0]    offs   [ROWS];

  logic signed [PRW-1:0]   prod_nxt [MAT_ENTRIES];
  logic signed [PRW-1:0]   prod_r   [MAT_ENTRIES];
  logic signed [2*CW-1:0]  tw_nxt   [ROWS];
  logic signed [2*CW-1:0]  tw_r     [ROWS];
  logic signed [RR_W-1:0]  rot_nxt  [ROWS];
  logic signed [RR_W-1:0]  rot_r    [ROWS];
  logic signed [TR_W-1:0]  trn_nxt  [ROWS];
  logic signed [TR_W-1:0]  trn_r    [ROWS];
  logic signed [CW-1:0]    res_nxt  [ROWS];
  logic signed [CW-1:0]    res_r    [ROWS];

  logic                    v3_r, v4_r, v5_r;
  logic signed [CW-1:0]    w3_r, w4_r, w5_r;

  always_comb begin
    pt[0]   = point_x;
    pt[1]   = point_y;
    pt[2]   = point_z;
    offs[0] = offset_x;
    offs[1] = offset_y;
    offs[2] = offset_z;
  end

  // stage 3: matrix by point and translation by weight
  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      for (int j = 0; j < ROWS; j++) begin
        prod_nxt[i*ROWS+j] = PRW'(mat[i*ROWS+j]) * PRW'(pt[j]);
      end
      tw_nxt[i] = (2*CW)'(offs[i]) * (2*CW)'(point_w);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    tw_r   <= tw_nxt;
    w3_r   <= point_w;
  end

  // stage 4: row sums and rounding of both parts
  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      logic signed [ROT_W-1:0] acc;
      logic signed [TW_W-1:0]  tw_ext;
      acc = ROT_W'(prod_r[i*ROWS]) + ROT_W'(prod_r[i*ROWS+1]) + ROT_W'(prod_r[i*ROWS+2])
            + (ROT_W'(1) <<< (QF - 1));
      rot_nxt[i] = RR_W'(acc >>> QF);
      tw_ext = TW_W'(tw_r[i]) + (TW_W'(1) <<< (CF - 1));
      trn_nxt[i] = TR_W'(tw_ext >>> CF);
    end
  end

  always_ff @(posedge clk) begin
    rot_r <= rot_nxt;
    trn_r <= trn_nxt;
    w4_r  <= w3_r;
  end

  // stage 5: final add and saturation to the coordinate range
  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      logic signed [SUM_W-1:0] sum;
      logic                    fits;
      sum  = SUM_W'(rot_r[i]) + SUM_W'(trn_r[i]);
      fits = (&sum[SUM_W-1:CW-1]) | ~(|sum[SUM_W-1:CW-1]);
      if (fits) begin
        res_nxt[i] = sum[CW-1:0];
      end else if (sum[SUM_W-1]) begin
        res_nxt[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        res_nxt[i] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    w5_r  <= w4_r;
  end

  // valid bits travel with the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v3_r <= in_valid;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  assign out_valid = v5_r;
  assign moved_x   = res_r[0];
  assign moved_y   = res_r[1];
  assign moved_z   = res_r[2];
  assign moved_w   = w5_r;

endmodule

`default_nettype wire
